// ===== sv/rsc_pkg.sv =====
`timescale 1ns / 1ps

package rsc_pkg;

    // Width of the running value and depth of the digit buffer.
    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 32;

    // Derived widths.
    localparam int DIG_W   = 6;
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W  = $clog2(VALUE_BITS);
    localparam int BASE_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Character constants.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;

    // Reset radix and the smallest usable output radix.
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IN_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_BASE = 2'd1;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              char_last;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } out_word_t;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_START,
        ST_DIV,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

// ===== sv/rsc_divider.sv =====
`timescale 1ns / 1ps

module rsc_divider import rsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIG_W-1:0]      divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIG_W-1:0]      remainder,
    output div_status_t           status
);

    logic [VALUE_BITS-1:0] q_reg;
    logic [DIG_W-1:0]      rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIG_W:0]        trial;
    logic                  fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(VALUE_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DIG_W'(trial - {1'b0, divisor});
                q_reg   <= {q_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DIG_W-1:0];
                q_reg   <= {q_reg[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    assign quotient    = q_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/rsc_digit_buf.sv =====
`timescale 1ns / 1ps

module rsc_digit_buf import rsc_pkg::*; (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DIG_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DIG_W-1:0]  rd_data
);

    logic [DIG_W-1:0] mem [MAX_DIGITS];
    logic [DIG_W-1:0] rd_data_reg;

    // Remainders are written least significant first.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/radix_string_converter.sv =====
`timescale 1ns / 1ps

// Radix string converter.
// The input channel (s_valid, s_ready, s_data) takes one ASCII digit
// character per word, most significant first, with char_last on the final
// one. The value is built as value * in_base + digit, wrapping at 32 bits.
// On the final character the value is converted to out_base and the digits
// leave on the result channel (m_valid, m_ready, m_data) most significant
// first as uppercase ASCII, with out_last on the final digit.
// Ordinary characters are taken one per cycle. After the final character,
// each output digit costs one divider pass (one quotient bit per cycle in
// the serial divider), then each digit is read from the digit buffer in
// ST_READ and shown in ST_OUT while the receiver takes it. A stalled
// receiver holds the current digit on m_data and the block takes no new
// character until the whole number has been delivered.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes in_base (index 0) and out_base (index 1); write it only when idle.
// Reset sets both radixes to ten and clears the running value; the digit
// buffer needs no clearing.
module radix_string_converter import rsc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0]    cfg_data
);

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ADDR_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [BASE_W-1:0]     in_base_reg;
    logic [BASE_W-1:0]     out_base_reg;

    logic [BASE_W-1:0]     out_radix;
    logic [VALUE_BITS-1:0] worth;
    logic [VALUE_BITS-1:0] acc_step;
    logic [CNT_W-1:0]      cnt_inc;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DIG_W-1:0]      div_rem;
    div_status_t           div_st;

    logic                  buf_wr;
    logic                  buf_rd;
    logic [DIG_W-1:0]      buf_data;
    logic [CHAR_W-1:0]     dig_char;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_base_reg  <= BASE_RESET;
            out_base_reg <= BASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IN_BASE) begin
                in_base_reg <= cfg_data;
            end else if (cfg_index == CFG_OUT_BASE) begin
                out_base_reg <= cfg_data;
            end
        end
    end

    // Radix below two is treated as two.
    assign out_radix = (out_base_reg < BASE_MIN) ? BASE_MIN : out_base_reg;

    // Character value; anything that is not a digit or lowercase letter
    // uses the uppercase formula and may wrap.
    always_comb begin
        if (s_data.digit_char >= CHAR_ZERO && s_data.digit_char <= CHAR_NINE) begin
            worth = VALUE_BITS'(s_data.digit_char) - VALUE_BITS'(CHAR_ZERO);
        end else if (s_data.digit_char >= CHAR_LOW_A && s_data.digit_char <= CHAR_LOW_Z) begin
            worth = VALUE_BITS'(s_data.digit_char) - VALUE_BITS'(CHAR_LOW_A)
                    + VALUE_BITS'(DIGIT_TEN);
        end else begin
            worth = VALUE_BITS'(s_data.digit_char) - VALUE_BITS'(CHAR_UP_A)
                    + VALUE_BITS'(DIGIT_TEN);
        end
    end

    assign acc_step = VALUE_BITS'(acc_reg * VALUE_BITS'(in_base_reg)) + worth;
    assign cnt_inc  = cnt_reg + 1'b1;

    rsc_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (acc_reg),
        .divisor   (out_radix),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_st)
    );

    rsc_digit_buf u_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (div_rem),
        .rd_en   (buf_rd),
        .rd_addr (rd_idx_reg),
        .rd_data (buf_data)
    );

    // Digit to ASCII: 0-9, then 'A' onward.
    assign dig_char = (CHAR_W'(buf_data) < DIGIT_TEN)
                    ? CHAR_W'(buf_data) + CHAR_ZERO
                    : CHAR_W'(buf_data) - DIGIT_TEN + CHAR_UP_A;

    assign m_data.out_char = dig_char;
    assign m_data.out_last = (rd_idx_reg == '0);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_ACCUM;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Sequencer: accumulate, divide per digit, then read digits back in reverse.
    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        div_start   = 1'b0;
        buf_wr      = 1'b0;
        buf_rd      = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    acc_next = acc_step;
                    if (s_data.char_last) begin
                        cnt_next   = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_st.done) begin
                    buf_wr = 1'b1;
                    if (div_quot != '0 && cnt_inc < CNT_W'(MAX_DIGITS)) begin
                        acc_next   = div_quot;
                        cnt_next   = cnt_inc;
                        state_next = ST_START;
                    end else begin
                        acc_next    = '0;
                        rd_idx_next = cnt_reg[ADDR_W-1:0];
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                buf_rd     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (rd_idx_reg == '0) begin
                        state_next = ST_ACCUM;
                    end else begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

// ===== dv/tb_radix_string_converter.sv =====
`timescale 1ns / 1ps

module tb_radix_string_converter;
    import rsc_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    // One divider pass plus margin, so the block is quiet before a register write.
    localparam int SETTLE_CYCLES   = VALUE_BITS + 8;
    localparam int CYCLE_LIMIT     = 4000000;
    // Long enough to outlast the conversion of the first held number, so
    // its digits wait at the output while the next number is offered.
    localparam int HOLD_CYCLES     = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int CHARS_PER_PHASE = 40;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_word_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_word_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BASE_W-1:0]    cfg_data;

    // Shadow copy of the converter state and its radix registers.
    logic [VALUE_BITS-1:0] run_value;
    logic [BASE_W-1:0]     in_radix;
    logic [BASE_W-1:0]     out_radix;
    out_word_t             pending_digits[$];

    int error_count;
    bit idle_on;
    bit hold_active;

    radix_string_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Worth of one character; anything outside the digit and lowercase
    // ranges goes through the uppercase formula and may wrap.
    function automatic logic [VALUE_BITS-1:0] char_value(logic [CHAR_W-1:0] ch);
        logic [VALUE_BITS-1:0] wide;
        wide = VALUE_BITS'(ch);
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            return wide - VALUE_BITS'(CHAR_ZERO);
        if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z)
            return wide - VALUE_BITS'(CHAR_LOW_A) + VALUE_BITS'(DIGIT_TEN);
        return wide - VALUE_BITS'(CHAR_UP_A) + VALUE_BITS'(DIGIT_TEN);
    endfunction

    // Fold one accepted character into the running value. On the final
    // character, convert and queue the output digits, most significant first.
    function automatic void absorb_char(in_word_t w);
        logic [VALUE_BITS-1:0] v;
        logic [BASE_W-1:0]     radix;
        logic [DIG_W-1:0]      digs[MAX_DIGITS];
        logic [DIG_W-1:0]      d;
        out_word_t             o;
        int                    n;
        run_value = run_value * VALUE_BITS'(in_radix) + char_value(w.digit_char);
        if (!w.char_last)
            return;
        // An output radix below two saturates to two.
        radix = (out_radix < BASE_MIN) ? BASE_MIN : out_radix;
        v = run_value;
        n = 0;
        do begin
            digs[n] = DIG_W'(v % VALUE_BITS'(radix));
            n++;
            v = v / VALUE_BITS'(radix);
        end while (v != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            d = digs[k];
            o.out_char = (d < DIG_W'(DIGIT_TEN)) ? CHAR_ZERO + CHAR_W'(d)
                                                 : CHAR_UP_A + CHAR_W'(d) - DIGIT_TEN;
            o.out_last = (k == 0);
            pending_digits.push_back(o);
        end
        run_value = '0;
    endfunction

    task automatic flag_error(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Offer one character word, after a random gap when idling is on, and hold it until taken.
    task automatic send_char(logic [CHAR_W-1:0] ch, logic last);
        in_word_t w;
        int       gap;
        w.digit_char = ch;
        w.char_last  = last;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        absorb_char(w);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    // Stop offering words, wait until every queued digit has come out, then let the block settle.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_digits.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BASE_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IN_BASE:  in_radix  = value;
            CFG_OUT_BASE: out_radix = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_radixes(logic [BASE_W-1:0] in_r, logic [BASE_W-1:0] out_r);
        drain();
        write_reg(CFG_IN_BASE, in_r);
        write_reg(CFG_OUT_BASE, out_r);
    endtask

    // Mostly the common radixes and the legal extremes, now and then any value.
    function automatic logic [BASE_W-1:0] pick_radix();
        case ($urandom_range(0, 5))
            0:       return BASE_MIN;
            1:       return 6'd36;
            2:       return BASE_RESET;
            3:       return 6'd16;
            default: return BASE_W'($urandom_range(0, 63));
        endcase
    endfunction

    // Decimal to decimal straight out of reset.
    task automatic test_reset_defaults();
        idle_on = 1'b1;
        send_text("0");
        send_text("255");
    endtask

    // Each character class as a one-character number, plus both byte extremes.
    task automatic test_char_classes();
        set_radixes(6'd36, 6'd36);
        send_text("9");
        send_text("a");
        send_text("z");
        send_text("A");
        send_text("Z");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    // Longest output, radixes outside the legal range, and value wrap.
    task automatic test_radix_extremes();
        set_radixes(6'd16, BASE_MIN);
        send_text("ffffffff");
        set_radixes(6'd63, 6'd0);
        send_text("1!");
        set_radixes(6'd0, 6'd63);
        send_char(8'hFF, 1'b1);
        set_radixes(6'd1, 6'd1);
        send_text("777");
    endtask

    // Writes to indexes with no register behind them must change nothing.
    task automatic test_spare_indexes();
        drain();
        write_reg(CFG_SPARE_2, 6'h3F);
        write_reg(CFG_SPARE_3, 6'h00);
        send_text("7");
    endtask

    // Random numbers over several radix settings, with and without idling.
    task automatic test_random_numbers();
        logic [CHAR_W-1:0] ch;
        logic [BASE_W-1:0] d;
        int                sent;
        int                len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_radixes(pick_radix(), pick_radix());
            idle_on = (phase % 3) != 2;
            sent = 0;
            while (sent < CHARS_PER_PHASE) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    // Mostly digits legal for the input radix, in either case.
                    if (in_radix >= BASE_MIN && in_radix <= 6'd36
                        && $urandom_range(0, 4) != 0) begin
                        d = BASE_W'($urandom_range(0, in_radix - 1));
                        if (d < BASE_W'(DIGIT_TEN))
                            ch = CHAR_ZERO + CHAR_W'(d);
                        else if ($urandom_range(0, 1) != 0)
                            ch = CHAR_LOW_A + CHAR_W'(d) - DIGIT_TEN;
                        else
                            ch = CHAR_UP_A + CHAR_W'(d) - DIGIT_TEN;
                    end else begin
                        ch = CHAR_W'($urandom_range(0, 255));
                    end
                    send_char(ch, i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    // The receiver stops for a long stretch while numbers keep coming, so the
    // converter fills up and holds off its input.
    task automatic test_receiver_hold();
        set_radixes(BASE_RESET, BASE_MIN);
        idle_on = 1'b0;
        fork
            begin
                @(posedge aclk);
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end
        join_none
        for (int n = 0; n < 3; n++)
            for (int i = 0; i < 10; i++)
                send_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)), i == 9);
    endtask

    // The sender waits for every digit of one number before the next.
    task automatic test_sender_pause();
        set_radixes(6'd16, 6'd36);
        idle_on = 1'b1;
        for (int n = 0; n < 2; n++) begin
            for (int i = 0; i < 8; i++)
                send_char(CHAR_LOW_A + CHAR_W'($urandom_range(0, 5)), i == 7);
            drain();
        end
    endtask

    // Receiver: random stall after each digit word when idling is on, or a long hold when asked.
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_active || stall > 0) begin
                m_ready = 1'b0;
                if (!hold_active)
                    stall--;
            end else begin
                m_ready = 1'b1;
            end
            @(posedge aclk);
            if (m_valid && m_ready)
                stall = idle_on ? $urandom_range(0, 19) : 0;
        end
    end

    // Compare every digit word taken with the oldest one predicted.
    always @(posedge aclk) begin : check_digit
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_digits.size() == 0) begin
                flag_error($sformatf("unexpected digit char=%02h last=%0b",
                                     m_data.out_char, m_data.out_last));
            end else begin
                want = pending_digits.pop_front();
                if (m_data.out_char !== want.out_char)
                    flag_error($sformatf("out_char %02h, want %02h",
                                         m_data.out_char, want.out_char));
                if (m_data.out_last !== want.out_last)
                    flag_error($sformatf("out_last %0b, want %0b",
                                         m_data.out_last, want.out_last));
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_radix_string_converter: FAIL");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_on     = 1'b1;
        hold_active = 1'b0;
        error_count = 0;
        run_value   = '0;
        in_radix    = BASE_RESET;
        out_radix   = BASE_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_char_classes();
        test_radix_extremes();
        test_spare_indexes();
        test_receiver_hold();
        test_sender_pause();
        test_random_numbers();

        drain();
        if (error_count == 0)
            $display("tb_radix_string_converter: PASS");
        else
            $display("tb_radix_string_converter: FAIL");
        $finish;
    end

endmodule
